[rtl/gll_pkg.sv]
// Shared constants and types for the greedy least-loaded scheduler.
package gll_pkg;

	localparam int MAX_CORES  = 16;
	localparam int CORE_W     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int CNT_W      = $clog2(MAX_CORES + 1);
	localparam int CFG_W      = 5;
	localparam int LEN_W      = 16;
	localparam int LOAD_W     = 32;
	localparam int OUT_CORE_W = 4;

	localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

	localparam logic MODE_ASSIGN = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

	localparam logic [CFG_W-1:0] NUM_CORES_RESET = CFG_W'(4);

	typedef logic [CORE_W-1:0] core_idx_t;
	typedef logic [LOAD_W-1:0] load_t;

	typedef struct packed {
		load_t     min_load;
		core_idx_t min_core;
		load_t     max_load;
		core_idx_t max_core;
	} scan_res_t;

endpackage

[rtl/gll_if.sv]
// Job and result channel interfaces of the greedy least-loaded scheduler.
interface gll_job_if import gll_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [LEN_W-1:0] job_length;

	modport source (output valid, output mode, output job_length, input ready);
	modport sink (input valid, input mode, input job_length, output ready);
endinterface

interface gll_res_if import gll_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OUT_CORE_W-1:0] assigned_core;
	logic [LOAD_W-1:0]     core_load;
	logic [LOAD_W-1:0]     makespan;
	logic [OUT_CORE_W-1:0] makespan_core;
	logic                  any_load;
	logic                  saturated;

	modport source (output valid, output assigned_core, output core_load, output makespan,
		output makespan_core, output any_load, output saturated, input ready);
	modport sink (input valid, input assigned_core, input core_load, input makespan,
		input makespan_core, input any_load, input saturated, output ready);
endinterface

[rtl/gll_scan.sv]
// Shared compare unit that finds the least and greatest load, one core per cycle.
module gll_scan import gll_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  logic      first,
	input  core_idx_t idx,
	input  load_t     load,
	output scan_res_t res
);

	scan_res_t res_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (first) begin
				res_q.min_load <= load;
				res_q.min_core <= idx;
				res_q.max_load <= load;
				res_q.max_core <= idx;
			end else begin
				if (load < res_q.min_load) begin
					res_q.min_load <= load;
					res_q.min_core <= idx;
				end
				if (load > res_q.max_load) begin
					res_q.max_load <= load;
					res_q.max_core <= idx;
				end
			end
		end
	end

	assign res = res_q;

endmodule

[rtl/greedy_least_loaded_scheduler_unit.sv]
// Top level of the greedy least-loaded scheduler: load store, sequencer and result register.
//
//   channel   direction  handshake        content
//   job       in         valid/ready      mode, job_length
//   res       out        valid/ready      assigned_core, core_load, makespan, makespan_core,
//                                         any_load, saturated
//   cfg       in         cfg_we           cfg_wdata = num_cores
//
// An assign item scans the stored load of each of the n cores in use before it finishes,
// because the shared compare unit visits one stored load per cycle. A clear skips the scan.
// Reset zeroes all loads and sets num_cores to four. A stalled result holds the final
// cycle of the next item until the result register is free.
module greedy_least_loaded_scheduler_unit import gll_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	gll_job_if.sink          job,
	gll_res_if.source        res,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] num_cores_q;
	core_idx_t        idx_q;
	core_idx_t        last_q;
	logic             mode_q;
	logic [LEN_W-1:0] len_q;
	load_t            loads_q [MAX_CORES];

	logic                  res_valid_q;
	logic [OUT_CORE_W-1:0] res_core_q;
	load_t                 res_load_q;
	load_t                 res_span_q;
	logic [OUT_CORE_W-1:0] res_span_core_q;
	logic                  res_any_q;
	logic                  res_sat_q;

	logic [CNT_W-1:0] n_eff;
	scan_res_t        scan;
	logic             scan_en;
	logic             out_free;
	logic             job_xfer;
	logic [LOAD_W:0]  sum;
	logic             sat;
	load_t            new_load;
	load_t            new_max;
	core_idx_t        new_max_core;

	always_comb begin
		if (num_cores_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(num_cores_q) > MAX_CORES) begin
			n_eff = CNT_W'(MAX_CORES);
		end else begin
			n_eff = CNT_W'(num_cores_q);
		end
	end

	assign job.ready = (state_q == ST_IDLE);
	assign job_xfer  = job.valid && job.ready;
	assign scan_en   = (state_q == ST_SCAN);
	assign out_free  = !res_valid_q || res.ready;

	gll_scan u_scan (
		.clk   (clk),
		.en    (scan_en),
		.first (idx_q == '0),
		.idx   (idx_q),
		.load  (loads_q[idx_q]),
		.res   (scan)
	);

	always_comb begin
		sum      = {1'b0, scan.min_load} + (LOAD_W + 1)'(len_q);
		sat      = sum[LOAD_W];
		new_load = sat ? LOAD_MAX : sum[LOAD_W-1:0];
		if (new_load > scan.max_load
				|| (new_load == scan.max_load && scan.min_core < scan.max_core)) begin
			new_max      = new_load;
			new_max_core = scan.min_core;
		end else begin
			new_max      = scan.max_load;
			new_max_core = scan.max_core;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cores_q <= NUM_CORES_RESET;
		end else if (cfg_we) begin
			num_cores_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_xfer) begin
						idx_q   <= '0;
						state_q <= (job.mode == MODE_CLEAR) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == last_q) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + CORE_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_xfer) begin
			mode_q <= job.mode;
			len_q  <= job.job_length;
			last_q <= CORE_W'(n_eff - CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CORES; i++) begin
				loads_q[i] <= '0;
			end
		end else if (state_q == ST_FINISH && out_free) begin
			if (mode_q == MODE_CLEAR) begin
				for (int i = 0; i < MAX_CORES; i++) begin
					loads_q[i] <= '0;
				end
			end else begin
				loads_q[scan.min_core] <= new_load;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			if (mode_q == MODE_CLEAR) begin
				res_core_q      <= '0;
				res_load_q      <= '0;
				res_span_q      <= '0;
				res_span_core_q <= '0;
				res_any_q       <= 1'b0;
				res_sat_q       <= 1'b0;
			end else begin
				res_core_q      <= OUT_CORE_W'(scan.min_core);
				res_load_q      <= new_load;
				res_span_q      <= new_max;
				res_span_core_q <= (new_max != '0) ? OUT_CORE_W'(new_max_core) : '0;
				res_any_q       <= (new_max != '0);
				res_sat_q       <= sat;
			end
		end
	end

	assign res.valid         = res_valid_q;
	assign res.assigned_core = res_core_q;
	assign res.core_load     = res_load_q;
	assign res.makespan      = res_span_q;
	assign res.makespan_core = res_span_core_q;
	assign res.any_load      = res_any_q;
	assign res.saturated     = res_sat_q;

`ifndef NO_ASSERTIONS
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= last_q))
		else $error("Scan index passed the last core in use.");

	a_assign_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(job_xfer && job.mode == MODE_ASSIGN) |=> (state_q == ST_SCAN && idx_q == '0))
		else $error("An assign transfer did not start a scan at core zero.");

	a_span_covers_load: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_span_q >= res_load_q))
		else $error("Makespan is below the load of the assigned core.");

	a_sat_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_sat_q) |-> (res_load_q == LOAD_MAX))
		else $error("Saturated result without a load at its maximum.");

	a_no_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_any_q) |-> (res_span_q == '0 && res_span_core_q == '0))
		else $error("Result without load reports a makespan.");
`endif

endmodule

[dv/greedy_least_loaded_scheduler_unit_test.sv]
// Self-checking testbench of the greedy least-loaded scheduler with its own scheduling predictor.
module greedy_least_loaded_scheduler_unit_test;
	import gll_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_JOBS = 112;

	typedef struct packed {
		logic             mode;
		logic [LEN_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic [OUT_CORE_W-1:0] core;
		load_t                 load;
		load_t                 span;
		logic [OUT_CORE_W-1:0] span_core;
		logic                  any;
		logic                  sat;
	} sched_res_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	gll_job_if job ();
	gll_res_if res ();

	greedy_least_loaded_scheduler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	load_t            core_loads [MAX_CORES];
	load_t            peak_load;
	int               peak_core;
	logic [CFG_W-1:0] core_cfg;

	job_t       job_queue [$];
	sched_res_t predicted_results [$];
	job_t       next_job;
	sched_res_t want;
	bit         steady;
	int         job_hold;
	int         res_hold;
	int         quiet_cycles;
	int         mismatches;

	function automatic int active_cores();
		int n;
		n = int'(core_cfg);
		if (n < 1) n = 1;
		if (n > MAX_CORES) n = MAX_CORES;
		return n;
	endfunction

	function automatic void rescan_peak();
		int n;
		n = active_cores();
		peak_load = '0;
		peak_core = 0;
		for (int i = 0; i < n; i++) begin
			if (core_loads[i] > peak_load) begin
				peak_load = core_loads[i];
				peak_core = i;
			end
		end
	endfunction

	function automatic sched_res_t schedule_job(job_t j);
		sched_res_t r;
		int pick;
		logic [LOAD_W:0] total;
		r = '0;
		if (j.mode == MODE_CLEAR) begin
			foreach (core_loads[i]) core_loads[i] = '0;
			peak_load = '0;
			peak_core = 0;
			return r;
		end
		pick = 0;
		for (int i = 1; i < active_cores(); i++) begin
			if (core_loads[i] < core_loads[pick]) pick = i;
		end
		total = {1'b0, core_loads[pick]} + j.len;
		if (total > {1'b0, LOAD_MAX}) begin
			total = {1'b0, LOAD_MAX};
			r.sat = 1'b1;
		end
		core_loads[pick] = total[LOAD_W-1:0];
		if (core_loads[pick] > peak_load || (core_loads[pick] == peak_load && pick < peak_core)) begin
			peak_load = core_loads[pick];
			peak_core = pick;
		end
		r.core = OUT_CORE_W'(pick);
		r.load = core_loads[pick];
		r.span = peak_load;
		r.any = (peak_load != '0);
		r.span_core = r.any ? OUT_CORE_W'(peak_core) : '0;
		return r;
	endfunction

	function automatic job_t random_job();
		job_t j;
		j.mode = ($urandom_range(0, 39) == 0) ? MODE_CLEAR : MODE_ASSIGN;
		case ($urandom_range(0, 7))
			0: j.len = '0;
			1: j.len = '1;
			2: j.len = LEN_W'($urandom_range(0, 15));
			default: j.len = LEN_W'($urandom());
		endcase
		return j;
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (job_queue.size() != 0 || job.valid || predicted_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_core_count(input logic [CFG_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		core_cfg = value;
		rescan_peak();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_job(input logic mode, input logic [LEN_W-1:0] len);
		job_t j;
		j.mode = mode;
		j.len = len;
		job_queue.insert(job_queue.size(), j);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job.valid <= 1'b0;
			job.mode <= MODE_ASSIGN;
			job.job_length <= '0;
			job_hold = 0;
		end else begin
			if (job.valid && job.ready) begin
				predicted_results.insert(predicted_results.size(),
					schedule_job({job.mode, job.job_length}));
				job_hold = steady ? 0 : $urandom_range(0, 4);
			end
			if (!job.valid || job.ready) begin
				if (job_hold > 0) begin
					job_hold--;
					job.valid <= 1'b0;
				end else if (job_queue.size() != 0) begin
					next_job = job_queue.pop_front();
					job.valid <= 1'b1;
					job.mode <= next_job.mode;
					job.job_length <= next_job.len;
				end else begin
					job.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			res_hold = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result transfer with no prediction pending");
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					if (res.assigned_core !== want.core) begin
						$error("assigned_core: expected %0d, actual %0d", want.core, res.assigned_core);
						mismatches++;
					end
					if (res.core_load !== want.load) begin
						$error("core_load: expected %0d, actual %0d", want.load, res.core_load);
						mismatches++;
					end
					if (res.makespan !== want.span) begin
						$error("makespan: expected %0d, actual %0d", want.span, res.makespan);
						mismatches++;
					end
					if (res.makespan_core !== want.span_core) begin
						$error("makespan_core: expected %0d, actual %0d", want.span_core,
							res.makespan_core);
						mismatches++;
					end
					if (res.any_load !== want.any) begin
						$error("any_load: expected %0d, actual %0d", want.any, res.any_load);
						mismatches++;
					end
					if (res.saturated !== want.sat) begin
						$error("saturated: expected %0d, actual %0d", want.sat, res.saturated);
						mismatches++;
					end
				end
				res_hold = steady ? 0 : $urandom_range(0, 4);
			end
			if (res_hold > 0) begin
				res_hold--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((job.valid && job.ready) || (res.valid && res.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		job.valid = 1'b0;
		job.mode = MODE_ASSIGN;
		job.job_length = '0;
		res.ready = 1'b0;
		steady = 1'b0;
		quiet_cycles = 0;
		mismatches = 0;
		foreach (core_loads[i]) core_loads[i] = '0;
		peak_load = '0;
		peak_core = 0;
		core_cfg = NUM_CORES_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		push_job(MODE_ASSIGN, 16'h0000);
		push_job(MODE_ASSIGN, 16'h0000);
		push_job(MODE_ASSIGN, 16'hFFFF);
		push_job(MODE_ASSIGN, 16'h0001);
		push_job(MODE_ASSIGN, 16'h8000);
		push_job(MODE_ASSIGN, 16'hFFFF);
		push_job(MODE_ASSIGN, 16'h7FFF);
		push_job(MODE_ASSIGN, 16'h0000);
		push_job(MODE_ASSIGN, 16'h0001);
		push_job(MODE_CLEAR, 16'hFFFF);
		push_job(MODE_ASSIGN, 16'h1234);
		for (int i = 0; i < 5; i++) push_job(MODE_ASSIGN, 16'hFFFF);
		push_job(MODE_CLEAR, 16'h0000);
		push_job(MODE_ASSIGN, 16'h5555);
		push_job(MODE_ASSIGN, 16'hAAAA);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: write_core_count(CFG_W'(16));
				1: write_core_count(CFG_W'(0));
				2: write_core_count(CFG_W'(31));
				3: write_core_count(CFG_W'(17));
				4: write_core_count(CFG_W'(1));
				5: write_core_count(CFG_W'(4));
				default: write_core_count(CFG_W'($urandom_range(0, 31)));
			endcase
			steady = (p % 4 == 3);
			if (p == 0 || $urandom_range(0, 1) == 1) push_job(MODE_CLEAR, LEN_W'($urandom()));
			for (int i = 0; i < PHASE_JOBS; i++) job_queue.insert(job_queue.size(), random_job());
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
